// ===== design/hsalsa_pkg.sv =====
// Shared types, constants and helpers for the HSalsa20 subkey derivation block.
package hsalsa_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [15:0][31:0] t_state;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_KEY_LOW      = 3'd0,
        REG_KEY_MID_LOW  = 3'd1,
        REG_KEY_MID_HIGH = 3'd2,
        REG_KEY_HIGH     = 3'd3,
        REG_ROUND_COUNT  = 3'd4
    } t_reg_index;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 64;

    localparam logic [7:0] RoundCountReset   = 8'd20;
    localparam logic [7:0] RoundCountDefault = 8'd20;

    // "expand 32-byte k"
    localparam t_word Sigma0 = 32'h6170_7865;
    localparam t_word Sigma1 = 32'h3320_646e;
    localparam t_word Sigma2 = 32'h7962_2d32;
    localparam t_word Sigma3 = 32'h6b20_6574;

    localparam int unsigned Rot0 = 7;
    localparam int unsigned Rot1 = 9;
    localparam int unsigned Rot2 = 13;
    localparam int unsigned Rot3 = 18;

    typedef struct packed {
        logic [63:0] nonce_first;
        logic [63:0] nonce_second;
        logic [63:0] nonce_third;
    } t_in_item;

    typedef struct packed {
        logic [63:0] subkey_low;
        logic [63:0] subkey_mid_low;
        logic [63:0] subkey_mid_high;
        logic [63:0] subkey_high;
        logic [63:0] inner_nonce;
        logic        status;
    } t_out_item;

    // Control from the top-level sequencer to the round core
    typedef struct packed {
        logic load;
        logic advance;
    } t_core_ctrl;

    function automatic t_word rotl(input t_word v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

endpackage

// ===== design/hsalsa20_subkey_derivation.sv =====
// Top level of the HSalsa20 subkey derivation block.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  input   | in        | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  output  | out       | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//  config  | in        | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// Each item runs R rounds (0 meaning 20) through the shared quarter-round
// unit, which does one add-rotate-xor step per column per cycle.
// An odd round count skips the rounds and yields an error result.
// Reset is synchronous, active low; it restores the key to zero and R to 20.
// A result waiting under i_out_stall holds the output register; the core then
// takes the next item, and a finished item waits in the hold state.
module hsalsa20_subkey_derivation
    import hsalsa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_data,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_data,
    // configuration writes
    input  logic                     i_cfg_we,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [CfgDataWidth-1:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_seq_state;

    t_seq_state r_seq, n_seq;

    // Configuration registers
    logic [63:0] r_key_low, r_key_mid_low, r_key_mid_high, r_key_high;
    logic [7:0]  r_round_count;

    // Per-item context
    logic [63:0] r_inner_nonce;
    logic        r_err;

    // Output register
    logic        r_out_valid;
    t_out_item   r_out_data;

    t_core_ctrl  w_ctrl;
    t_state      w_init;
    t_state      w_state;
    logic        w_last;
    logic [7:0]  w_rounds;
    logic        w_in_xfer;
    logic        w_out_free;
    t_out_item   w_result;

    // Write one register; indexes beyond the list drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low      <= '0;
            r_key_mid_low  <= '0;
            r_key_mid_high <= '0;
            r_key_high     <= '0;
            r_round_count  <= RoundCountReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KEY_LOW:      r_key_low      <= i_cfg_data;
                REG_KEY_MID_LOW:  r_key_mid_low  <= i_cfg_data;
                REG_KEY_MID_HIGH: r_key_mid_high <= i_cfg_data;
                REG_KEY_HIGH:     r_key_high     <= i_cfg_data;
                REG_ROUND_COUNT:  r_round_count  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // A zero count means the default twenty rounds.
    assign w_rounds = (r_round_count == 8'd0) ? RoundCountDefault : r_round_count;

    // Build the initial state: constants on the diagonal, key, first two nonce fields.
    always_comb begin
        w_init     = '0;
        w_init[0]  = Sigma0;
        w_init[1]  = r_key_low[31:0];
        w_init[2]  = r_key_low[63:32];
        w_init[3]  = r_key_mid_low[31:0];
        w_init[4]  = r_key_mid_low[63:32];
        w_init[5]  = Sigma1;
        w_init[6]  = i_in_data.nonce_first[31:0];
        w_init[7]  = i_in_data.nonce_first[63:32];
        w_init[8]  = i_in_data.nonce_second[31:0];
        w_init[9]  = i_in_data.nonce_second[63:32];
        w_init[10] = Sigma2;
        w_init[11] = r_key_mid_high[31:0];
        w_init[12] = r_key_mid_high[63:32];
        w_init[13] = r_key_high[31:0];
        w_init[14] = r_key_high[63:32];
        w_init[15] = Sigma3;
    end

    assign o_in_stall = (r_seq != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_ctrl.load    = w_in_xfer;
    assign w_ctrl.advance = (r_seq == S_RUN);

    hsalsa_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_init   (w_init),
        .i_rounds (w_rounds),
        .o_state  (w_state),
        .o_last   (w_last)
    );

    // Sequencer: odd counts go straight to the hold state with an error.
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_seq = w_rounds[0] ? S_HOLD : S_RUN;
                end
            end
            S_RUN: begin
                if (w_last) begin
                    n_seq = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_seq = S_IDLE;
                end
            end
            default: n_seq = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= S_IDLE;
        end else begin
            r_seq <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_inner_nonce <= i_in_data.nonce_third;
            r_err         <= w_rounds[0];
        end
    end

    // Pick words 0,5,10,15,6,7,8,9; on an odd count zero all fields and set the status.
    always_comb begin
        w_result.subkey_low      = {w_state[5],  w_state[0]};
        w_result.subkey_mid_low  = {w_state[15], w_state[10]};
        w_result.subkey_mid_high = {w_state[7],  w_state[6]};
        w_result.subkey_high     = {w_state[9],  w_state[8]};
        w_result.inner_nonce     = r_inner_nonce;
        w_result.status          = 1'b0;
        if (r_err) begin
            w_result        = '0;
            w_result.status = 1'b1;
        end
    end

    // Output register: load from the hold state, drop after the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_seq == S_HOLD) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_seq == S_HOLD) && w_out_free) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== design/hsalsa_qr_unit.sv =====
// Shared add-rotate-xor unit: one quarter-round step on all four columns.
module hsalsa_qr_unit
    import hsalsa_pkg::*;
(
    input  t_state     i_state,
    input  logic [1:0] i_step,
    output t_state     o_state
);

    // Each column lane holds (a,b,c,d) at fixed slots; update slot 1 and
    // rotate the lane so the next step again targets slot 1.
    always_comb begin
        logic [3:0] p0, p1, p2, p3;
        t_word      sum;
        t_word      mixed;
        o_state = i_state;
        for (int q = 0; q < 4; q++) begin
            p0 = 4'(5 * q);
            p1 = 4'(5 * q + 4);
            p2 = 4'(5 * q + 8);
            p3 = 4'(5 * q + 12);
            sum = i_state[p0] + i_state[p3];
            case (i_step)
                2'd0:    mixed = rotl(sum, Rot0);
                2'd1:    mixed = rotl(sum, Rot1);
                2'd2:    mixed = rotl(sum, Rot2);
                default: mixed = rotl(sum, Rot3);
            endcase
            o_state[p0] = i_state[p1] ^ mixed;
            o_state[p1] = i_state[p2];
            o_state[p2] = i_state[p3];
            o_state[p3] = i_state[p0];
        end
    end

endmodule

// ===== design/hsalsa_core.sv =====
// Round core: state register, step and round counters around the shared unit.
module hsalsa_core
    import hsalsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_core_ctrl i_ctrl,
    input  t_state     i_init,
    input  logic [7:0] i_rounds,
    output t_state     o_state,
    output logic       o_last
);

    t_state     r_state;
    t_state     n_state;
    t_state     w_step;
    logic [1:0] r_step;
    logic [7:0] r_left;

    hsalsa_qr_unit u_qr (
        .i_state (r_state),
        .i_step  (r_step),
        .o_state (w_step)
    );

    // After the fourth step the lanes are back in place; transpose so the
    // next round (row round) runs on the same column wiring.
    always_comb begin
        n_state = w_step;
        if (r_step == 2'd3) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    n_state[4'(4 * r + c)] = w_step[4'(4 * c + r)];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_state <= i_init;
        end else if (i_ctrl.advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 2'd0;
            r_left <= 8'd0;
        end else if (i_ctrl.load) begin
            r_step <= 2'd0;
            r_left <= i_rounds;
        end else if (i_ctrl.advance) begin
            r_step <= r_step + 2'd1;
            if (r_step == 2'd3) begin
                r_left <= r_left - 8'd1;
            end
        end
    end

    assign o_last  = i_ctrl.advance && (r_step == 2'd3) && (r_left == 8'd1);
    assign o_state = r_state;

endmodule

// ===== design/hsalsa_checker.sv =====
// Port-level checker for the subkey derivation block, bound to the top level.
module hsalsa_port_checker
    import hsalsa_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_out_valid) && $past(i_out_stall))
            |-> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    // An error result carries zero fields.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status)
            |-> (o_out_data.subkey_low == '0 && o_out_data.subkey_mid_low == '0 &&
                 o_out_data.subkey_mid_high == '0 && o_out_data.subkey_high == '0 &&
                 o_out_data.inner_nonce == '0))
        else $error("error result with nonzero fields");

    // Busy right after an input transfer.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in flight");

    // A new result only comes from an item in flight.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(o_out_valid)) |-> $past(o_in_stall))
        else $error("result appeared with no item in flight");

endmodule

bind hsalsa20_subkey_derivation hsalsa_port_checker u_hsalsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
